### hw/rtl/owb_pkg.sv
// ----------------------------------------------------------------------------
// owb_pkg: shared types and constants for the 1-Wire bus master
// Function codes, operation states, timing register set and result record.
// ----------------------------------------------------------------------------
package owb_pkg;

  // Width of the slot/phase tick counter.
  localparam int COUNT_WIDTH = 10;
  // Width used to form timing targets before they are clipped to the counter.
  localparam int EXT_W = (COUNT_WIDTH > 11) ? COUNT_WIDTH : 11;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // Input function codes.
  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_RESET = 3'd1;
  localparam logic [2:0] FUNC_WBYTE = 3'd2;
  localparam logic [2:0] FUNC_RBYTE = 3'd3;
  localparam logic [2:0] FUNC_WBIT  = 3'd4;
  localparam logic [2:0] FUNC_RBIT  = 3'd5;

  // Phases within a reset sequence or a bit slot.
  localparam logic [1:0] PH_LOW     = 2'd0;
  localparam logic [1:0] PH_RELEASE = 2'd1;
  localparam logic [1:0] PH_TAIL    = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [2:0] REG_SHORT_LOW     = 3'd3;
  localparam logic [2:0] REG_LONG_LOW      = 3'd4;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd5;
  localparam logic [2:0] REG_SLOT          = 3'd6;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_RESET = 3'd1,
    OP_WBYTE = 3'd2,
    OP_RBYTE = 3'd3,
    OP_WBIT  = 3'd4,
    OP_RBIT  = 3'd5
  } op_t;

  typedef struct packed {
    logic [9:0] reset_low_us;
    logic [9:0] presence_wait_us;
    logic [9:0] reset_tail_us;
    logic [7:0] short_low_us;
    logic [7:0] long_low_us;
    logic [7:0] read_sample_us;
    logic [7:0] slot_us;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] data_out;
    logic       rejected;
  } res_t;

  function automatic logic [COUNT_WIDTH-1:0] clip_cnt(input logic [EXT_W-1:0] v);
    if (v > EXT_W'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return v[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [EXT_W-1:0] max_ext(input logic [EXT_W-1:0] a,
                                               input logic [EXT_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

### hw/rtl/owb_cfg_regs.sv
// ----------------------------------------------------------------------------
// owb_cfg_regs: timing register file
// Holds the seven bus timing values, written through the configuration port.
// ----------------------------------------------------------------------------
module owb_cfg_regs
  import owb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [2:0] wr_index,
  input  logic [9:0] wr_data,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_RESET_LOW:     cfg_nxt.reset_low_us     = wr_data;
        REG_PRESENCE_WAIT: cfg_nxt.presence_wait_us = wr_data;
        REG_RESET_TAIL:    cfg_nxt.reset_tail_us    = wr_data;
        REG_SHORT_LOW:     cfg_nxt.short_low_us     = wr_data[7:0];
        REG_LONG_LOW:      cfg_nxt.long_low_us      = wr_data[7:0];
        REG_READ_SAMPLE:   cfg_nxt.read_sample_us   = wr_data[7:0];
        REG_SLOT:          cfg_nxt.slot_us          = wr_data[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_us     <= 10'd480;
      cfg_r.presence_wait_us <= 10'd70;
      cfg_r.reset_tail_us    <= 10'd410;
      cfg_r.short_low_us     <= 8'd6;
      cfg_r.long_low_us      <= 8'd60;
      cfg_r.read_sample_us   <= 8'd9;
      cfg_r.slot_us          <= 8'd70;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/owb_core.sv
// ----------------------------------------------------------------------------
// owb_core: bus sequencing state and per-item update
// Applies one tick or command to the sequencer state on each enabled step.
// ----------------------------------------------------------------------------
module owb_core
  import owb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [2:0] func,
  input  logic [7:0] data_in,
  input  logic       line_in,
  input  cfg_t       cfg,
  output res_t       res
);

  op_t                    op_r, op_nxt;
  logic [1:0]             phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [3:0]             bit_idx_r, bit_idx_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic                   pres_r, pres_nxt;
  logic                   drive_r, drive_nxt;
  logic [7:0]             rd_r, rd_nxt;

  always_comb begin
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   wbit;
    logic [EXT_W-1:0]       low_ext;
    logic [EXT_W-1:0]       samp_ext;
    logic                   slot_end;
    logic                   done;
    logic                   rej;
    logic [3:0]             bi_inc;

    op_nxt      = op_r;
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    pres_nxt    = pres_r;
    drive_nxt   = drive_r;
    rd_nxt      = rd_r;
    slot_end    = 1'b0;
    done        = 1'b0;
    rej         = 1'b0;

    cnt_inc  = (cnt_r < CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
    wbit     = (op_r == OP_WBYTE) ? shift_r[bit_idx_r[2:0]] : shift_r[0];
    low_ext  = EXT_W'(wbit ? cfg.short_low_us : cfg.long_low_us);
    samp_ext = EXT_W'(cfg.short_low_us) + EXT_W'(cfg.read_sample_us);
    bi_inc   = bit_idx_r + 4'd1;

    if (func == FUNC_TICK) begin
      if (op_r != OP_IDLE) begin
        cnt_nxt = cnt_inc;
        case (op_r)
          OP_RESET: begin
            if (phase_r == PH_LOW) begin
              if (cnt_inc >= clip_cnt(EXT_W'(cfg.reset_low_us))) begin
                drive_nxt = 1'b0;
                phase_nxt = PH_RELEASE;
                cnt_nxt   = '0;
              end
            end else if (phase_r == PH_RELEASE) begin
              if (cnt_inc >= clip_cnt(EXT_W'(cfg.presence_wait_us))) begin
                pres_nxt  = ~line_in;
                phase_nxt = PH_TAIL;
                cnt_nxt   = '0;
              end
            end else if (cnt_inc >= clip_cnt(EXT_W'(cfg.reset_tail_us))) begin
              done = 1'b1;
            end
          end
          OP_WBYTE, OP_WBIT: begin
            if (phase_r == PH_LOW) begin
              if (cnt_inc >= clip_cnt(low_ext)) begin
                drive_nxt = 1'b0;
                phase_nxt = PH_RELEASE;
              end
            end else if (cnt_inc >= clip_cnt(max_ext(EXT_W'(cfg.slot_us),
                                                     low_ext + 1'b1))) begin
              slot_end = 1'b1;
            end
          end
          default: begin
            // Read slot: short low pulse, sample, then finish the slot.
            if (phase_r == PH_LOW) begin
              if (cnt_inc >= clip_cnt(EXT_W'(cfg.short_low_us))) begin
                drive_nxt = 1'b0;
                phase_nxt = PH_RELEASE;
              end
            end else if (phase_r == PH_RELEASE) begin
              if (cnt_inc >= clip_cnt(samp_ext)) begin
                if (line_in) begin
                  if (op_r == OP_RBIT) begin
                    shift_nxt = 8'd1;
                  end else begin
                    shift_nxt[bit_idx_r[2:0]] = 1'b1;
                  end
                end
                phase_nxt = PH_TAIL;
              end
            end else if (cnt_inc >= clip_cnt(max_ext(EXT_W'(cfg.slot_us),
                                                     samp_ext + 1'b1))) begin
              slot_end = 1'b1;
            end
          end
        endcase

        if (slot_end) begin
          if (op_r == OP_WBIT) begin
            done = 1'b1;
          end else if (op_r == OP_RBIT) begin
            rd_nxt = {7'd0, shift_r[0]};
            done   = 1'b1;
          end else begin
            bit_idx_nxt = bi_inc;
            if (bi_inc >= 4'd8) begin
              if (op_r == OP_RBYTE) begin
                rd_nxt = shift_r;
              end
              done = 1'b1;
            end else begin
              phase_nxt = PH_LOW;
              cnt_nxt   = '0;
              drive_nxt = 1'b1;
            end
          end
        end

        if (done) begin
          op_nxt    = OP_IDLE;
          phase_nxt = PH_LOW;
          cnt_nxt   = '0;
          drive_nxt = 1'b0;
        end
      end
    end else if (func inside {[FUNC_RESET:FUNC_RBIT]}) begin
      if (op_r != OP_IDLE) begin
        rej = 1'b1;
      end else begin
        op_nxt      = op_t'(func);
        bit_idx_nxt = '0;
        case (func)
          FUNC_WBYTE: shift_nxt = data_in;
          FUNC_WBIT:  shift_nxt = {7'd0, data_in[0]};
          default:    shift_nxt = '0;
        endcase
        phase_nxt = PH_LOW;
        cnt_nxt   = '0;
        drive_nxt = 1'b1;
      end
    end

    res.drive_low = drive_nxt;
    res.busy_res  = (op_nxt != OP_IDLE);
    res.done_res  = done;
    res.presence  = pres_nxt;
    res.data_out  = rd_nxt;
    res.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r      <= OP_IDLE;
      phase_r   <= PH_LOW;
      cnt_r     <= '0;
      bit_idx_r <= '0;
      shift_r   <= '0;
      pres_r    <= 1'b0;
      drive_r   <= 1'b0;
      rd_r      <= '0;
    end else if (step_en) begin
      op_r      <= op_nxt;
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      pres_r    <= pres_nxt;
      drive_r   <= drive_nxt;
      rd_r      <= rd_nxt;
    end
  end

endmodule

### hw/rtl/one_wire_bus_master.sv
// Throughput: one tick or command per clock while the result register is not stalled.
// Each item passes an input register, the sequencer state update in owb_core, and a
// result register, so out_stall holds the input side only when both registers are full.
// Reset (rst_n low, synchronous) idles the sequencer, clears its bus drive, empties both
// registers and loads the default timing values.
// ----------------------------------------------------------------------------
// one_wire_bus_master: 1-Wire bus master timed by microsecond ticks
// Runs reset/presence, byte and bit write/read slots from tick and command items.
// ----------------------------------------------------------------------------
module one_wire_bus_master
  import owb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_func,
  input  logic [7:0] in_data_in,
  input  logic       in_line_in,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_drive_low,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic       out_presence,
  output logic [7:0] out_data_out,
  output logic       out_rejected,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_data
);

  logic       s1_valid_r;
  logic [2:0] s1_func_r;
  logic [7:0] s1_data_r;
  logic       s1_line_r;
  logic       out_valid_r;
  res_t       out_res_r;

  logic       advance;
  logic       in_take;
  cfg_t       cfg;
  res_t       step_res;

  // The update stage moves when the result register is free or being drained.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  owb_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  owb_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .func    (s1_func_r),
    .data_in (s1_data_r),
    .line_in (s1_line_r),
    .cfg     (cfg),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r <= in_func;
      s1_data_r <= in_data_in;
      s1_line_r <= in_line_in;
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_drive_low = out_res_r.drive_low;
  assign out_busy_res  = out_res_r.busy_res;
  assign out_done_res  = out_res_r.done_res;
  assign out_presence  = out_res_r.presence;
  assign out_data_out  = out_res_r.data_out;
  assign out_rejected  = out_res_r.rejected;

  // A completed command leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.done_res) |-> !out_res_r.busy_res)
    else $error("done reported while still busy");

  // A dropped command can only happen while another one is running.
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.rejected) |-> out_res_r.busy_res)
    else $error("command rejected while idle");

  // The bus is never pulled low by an idle master.
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.drive_low) |-> out_res_r.busy_res)
    else $error("bus driven low while idle");

  // The input register is only held when a stalled result blocks the update.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

endmodule
